### hw/rtl/coord_delta_zigzag_varint_encoder_defines.svh
// assertion macros shared by the encoder rtl
`ifndef COORD_DELTA_ZIGZAG_VARINT_ENCODER_DEFINES_SVH
`define COORD_DELTA_ZIGZAG_VARINT_ENCODER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define CDZV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be true outside reset
`define CDZV_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/cdzv_pkg.sv
// types, constants and helpers for the coordinate delta varint encoder
`default_nettype none

package cdzv_pkg;

  localparam int unsigned COORD_SHIFT = 5;
  localparam int unsigned PW          = 31;                 // point and base width
  localparam int unsigned CW          = PW - COORD_SHIFT;   // coarsened coordinate
  localparam int unsigned DW          = CW + 1;             // signed delta / zigzag
  localparam int unsigned BYTE_BITS   = 7;
  localparam int unsigned NB_MAX      = (DW + BYTE_BITS - 1) / BYTE_BITS;
  localparam int unsigned IW          = $clog2(NB_MAX);
  localparam int unsigned PADW        = NB_MAX * BYTE_BITS;
  localparam int unsigned CFG_IW      = 2;
  localparam int unsigned CFG_DW      = PW;

  typedef logic [CFG_IW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_BASE_X   = cfg_idx_t'(0);
  localparam cfg_idx_t REG_BASE_Y   = cfg_idx_t'(1);
  localparam cfg_idx_t REG_ZERO_SEP = cfg_idx_t'(2);

  localparam logic [BYTE_BITS-1:0] BYTE_MASK = 7'h7F;

  // one encoded point waiting to be sent out byte by byte
  typedef struct packed {
    logic          brk;
    logic [DW-1:0] zx;
    logic [IW-1:0] lx;
    logic [DW-1:0] zy;
    logic [IW-1:0] ly;
  } work_t;

  function automatic logic [DW-1:0] zigzag(input logic [DW-1:0] d);
    return {d[DW-2:0], 1'b0} ^ {DW{d[DW-1]}};
  endfunction

  // index of the last varint byte of z
  function automatic logic [IW-1:0] last_idx(input logic [DW-1:0] z);
    logic [IW-1:0] r;
    r = '0;
    for (int unsigned k = 1; k < NB_MAX; k++) begin
      if ((z >> (k * BYTE_BITS)) != '0) r = IW'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cdzv_if.sv
// handshake interfaces for points, code bytes and register writes
`default_nettype none

interface cdzv_point_if;
  logic                      valid;
  logic                      ready;
  logic [cdzv_pkg::PW-1:0]   point_x;
  logic [cdzv_pkg::PW-1:0]   point_y;
  logic                      restart;

  modport source (output valid, point_x, point_y, restart, input ready);
  modport sink   (input valid, point_x, point_y, restart, output ready);
endinterface

interface cdzv_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       ring_break;
  logic       last_of_point;

  modport source (output valid, code_byte, ring_break, last_of_point, input ready);
  modport sink   (input valid, code_byte, ring_break, last_of_point, output ready);
endinterface

interface cdzv_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cdzv_pkg::CFG_IW-1:0] index;
  logic [cdzv_pkg::CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/cdzv_serializer.sv
// holds one encoded point and sends its varint bytes through an output register
`default_nettype none
`include "coord_delta_zigzag_varint_encoder_defines.svh"

module cdzv_serializer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            work_valid_i,
  output logic                 work_ready_o,
  input  wire cdzv_pkg::work_t work_i,
  cdzv_code_if.source          code_o
);

  logic                         wv_q;
  cdzv_pkg::work_t              w_q;
  logic                         axis_q;   // 0: x delta, 1: y delta
  logic [cdzv_pkg::IW-1:0]      idx_q;

  logic                         oval_q;
  logic [7:0]                   obyte_q;
  logic                         obrk_q;
  logic                         olast_q;

  logic [cdzv_pkg::DW-1:0]        cur_z;
  logic [cdzv_pkg::IW-1:0]        cur_l;
  logic [cdzv_pkg::PADW-1:0]      pad;
  logic [cdzv_pkg::BYTE_BITS-1:0] bits;
  logic                           more;
  logic                           fin;
  logic                           o_free;
  logic                           step;
  logic                           take;

  always_comb begin
    cur_z  = axis_q ? w_q.zy : w_q.zx;
    cur_l  = axis_q ? w_q.ly : w_q.lx;
    pad    = cdzv_pkg::PADW'(cur_z);
    bits   = pad[idx_q * cdzv_pkg::BYTE_BITS +: cdzv_pkg::BYTE_BITS] & cdzv_pkg::BYTE_MASK;
    more   = (idx_q != cur_l);
    fin    = w_q.brk || (axis_q && !more);
    o_free = !oval_q || code_o.ready;
    step   = wv_q && o_free;
  end

  assign work_ready_o = !wv_q || (o_free && fin);
  assign take         = work_valid_i && work_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q   <= 1'b0;
      axis_q <= 1'b0;
      idx_q  <= '0;
    end else if (take) begin
      wv_q   <= 1'b1;
      axis_q <= 1'b0;
      idx_q  <= '0;
    end else if (step) begin
      if (fin) begin
        wv_q <= 1'b0;
      end else if (!more) begin
        axis_q <= 1'b1;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + cdzv_pkg::IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      w_q <= work_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (step) begin
      oval_q <= 1'b1;
    end else if (code_o.ready) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      obyte_q <= w_q.brk ? 8'h00 : {more, bits};
      obrk_q  <= w_q.brk;
      olast_q <= fin;
    end
  end

  assign code_o.valid         = oval_q;
  assign code_o.code_byte     = obyte_q;
  assign code_o.ring_break    = obrk_q;
  assign code_o.last_of_point = olast_q;

  `CDZV_ASSERT(a_idx_in_range, wv_q |-> (idx_q <= cur_l), "byte index past varint length")
  `CDZV_ASSERT(a_brk_single, (wv_q && w_q.brk) |-> (!axis_q && idx_q == '0), "ring break advanced")
  `CDZV_ASSERT(a_brk_out_last, (oval_q && obrk_q) |-> (olast_q && obyte_q == 8'h00), "bad ring break")
  `CDZV_ASSERT_NEVER(a_more_on_last, oval_q && olast_q && obyte_q[7], "last byte has more flag")

endmodule

`default_nettype wire

### hw/rtl/coord_delta_zigzag_varint_encoder.sv
// Coordinate delta / zigzag / varint encoder, top level.
//
// point_i takes one (point_x, point_y, restart) item per handshake. Each coordinate is
// shifted right by COORD_SHIFT, the previous coarsened point is subtracted, and the x then
// y delta leave on code_o as zigzag varint bytes, one byte per cycle unless code_o stalls,
// last_of_point on the final byte of the point. In separator mode a (0,0) point reseeds the
// predictor from the base registers and yields a single ring_break item.
// cfg_i writes base_x (index 0), base_y (index 1) and zero_is_separator (index 2); it is
// always ready and other indexes are dropped. Write it only while the block is idle.
// The point is encoded (from the coarsened base on restart) and the predictor updated in
// the accept cycle; the point register holds it while its bytes go to the output register.
// A point yields 2 to 8 bytes (1 to 4 per delta) and a ring break 1 byte, all through the
// single output byte register. The next point is taken in the cycle that its predecessor's
// last byte moves to the output register.
// Reset clears config, predictor and valid flags. When code_o stalls, the output byte holds,
// the held point waits, and point_i is back-pressured once the point register is full.
`default_nettype none
`include "coord_delta_zigzag_varint_encoder_defines.svh"

module coord_delta_zigzag_varint_encoder (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cdzv_cfg_if.sink     cfg_i,
  cdzv_point_if.sink   point_i,
  cdzv_code_if.source  code_o
);

  logic [cdzv_pkg::PW-1:0] base_x_q;
  logic [cdzv_pkg::PW-1:0] base_y_q;
  logic                    sep_en_q;
  logic [cdzv_pkg::CW-1:0] pred_x_q;
  logic [cdzv_pkg::CW-1:0] pred_y_q;

  logic [cdzv_pkg::CW-1:0] seed_x, seed_y;
  logic [cdzv_pkg::CW-1:0] px, py;
  logic [cdzv_pkg::CW-1:0] cx, cy;
  logic [cdzv_pkg::DW-1:0] dx, dy;
  logic                    sep;
  logic                    work_ready;
  logic                    accept;
  cdzv_pkg::work_t         work;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= '0;
      base_y_q <= '0;
      sep_en_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        cdzv_pkg::REG_BASE_X:   base_x_q <= cfg_i.data;
        cdzv_pkg::REG_BASE_Y:   base_y_q <= cfg_i.data;
        cdzv_pkg::REG_ZERO_SEP: sep_en_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    seed_x = cdzv_pkg::CW'(base_x_q >> cdzv_pkg::COORD_SHIFT);
    seed_y = cdzv_pkg::CW'(base_y_q >> cdzv_pkg::COORD_SHIFT);
    px     = point_i.restart ? seed_x : pred_x_q;
    py     = point_i.restart ? seed_y : pred_y_q;
    cx     = cdzv_pkg::CW'(point_i.point_x >> cdzv_pkg::COORD_SHIFT);
    cy     = cdzv_pkg::CW'(point_i.point_y >> cdzv_pkg::COORD_SHIFT);
    sep    = sep_en_q && (point_i.point_x == '0) && (point_i.point_y == '0);
    dx     = {1'b0, cx} - {1'b0, px};
    dy     = {1'b0, cy} - {1'b0, py};

    work.brk = sep;
    work.zx  = cdzv_pkg::zigzag(dx);
    work.lx  = cdzv_pkg::last_idx(work.zx);
    work.zy  = cdzv_pkg::zigzag(dy);
    work.ly  = cdzv_pkg::last_idx(work.zy);
  end

  assign point_i.ready = work_ready;
  assign accept        = point_i.valid && work_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_x_q <= '0;
      pred_y_q <= '0;
    end else if (accept) begin
      // a separator reseeds; an ordinary point becomes the next reference
      pred_x_q <= sep ? seed_x : cx;
      pred_y_q <= sep ? seed_y : cy;
    end
  end

  cdzv_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (point_i.valid),
    .work_ready_o (work_ready),
    .work_i       (work),
    .code_o       (code_o)
  );

  `CDZV_ASSERT(a_sep_x, (accept && sep) |=> (pred_x_q == $past(seed_x)), "x not reseeded")
  `CDZV_ASSERT(a_sep_y, (accept && sep) |=> (pred_y_q == $past(seed_y)), "y not reseeded")
  `CDZV_ASSERT(a_trk_x, (accept && !sep) |=> (pred_x_q == $past(cx)), "x pred not updated")
  `CDZV_ASSERT(a_trk_y, (accept && !sep) |=> (pred_y_q == $past(cy)), "y pred not updated")
  `CDZV_ASSERT(a_hold_x, !accept |=> $stable(pred_x_q), "x pred moved without item")
  `CDZV_ASSERT(a_hold_y, !accept |=> $stable(pred_y_q), "y pred moved without item")

endmodule

`default_nettype wire
